>>> sv/tsrdz_pkg.sv
// package for the thumbstick radial dead zone block
// types and constants shared by the square root cells, divider cells and top level
package tsrdz_pkg;

  localparam int unsigned AxisFullScaleDef = 32767;
  localparam int unsigned FracResetVal     = 4588;
  localparam int unsigned SqrtCells        = 32;
  localparam int unsigned RatioBits        = 30;
  localparam int unsigned OutOne           = 32767;

  // running state of one digit-by-digit square root
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_data_t;

  // item fields that ride along the square root row
  typedef struct packed {
    logic        nx;
    logic        ny;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [30:0] dz;
    logic        f_zero;
    logic        f_big;
    logic        mag_zero;
  } sq_side_t;

  // one lane of a restoring divider
  typedef struct packed {
    logic [62:0]          r;
    logic [62:0]          d;
    logic [RatioBits-1:0] q;
    logic                 ge;
  } dv_lane_t;

  // item fields that ride along the divider row
  typedef struct packed {
    logic nx;
    logic ny;
    logic zero_out;
    logic in_zone;
  } dv_side_t;

endpackage

>>> sv/tsrdz_sqrt_cell.sv
// one cell of the square root row: settles one result bit per cycle while en_i is high
// depends on tsrdz_pkg
module tsrdz_sqrt_cell
  import tsrdz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_data_t data_i,
  input  sq_side_t side_i,
  output logic     valid_o,
  output sq_data_t data_o,
  output sq_side_t side_o
);

  logic     valid_q;
  sq_data_t data_q, data_d;
  sq_side_t side_q;
  logic [35:0] rem_n;
  logic [36:0] trial;

  always_comb begin
    rem_n  = {data_i.rem, data_i.rad[63:62]};
    trial  = {1'b0, rem_n} - {3'b000, data_i.root, 2'b01};
    data_d = data_i;
    data_d.rad = {data_i.rad[61:0], 2'b00};
    if (!trial[36]) begin
      data_d.rem  = trial[33:0];
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = rem_n[33:0];
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

>>> sv/tsrdz_div_cell.sv
// one cell of the divider row: one quotient bit for each axis per cycle while en_i is high
// depends on tsrdz_pkg
module tsrdz_div_cell
  import tsrdz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  dv_lane_t lane_x_i,
  input  dv_lane_t lane_y_i,
  input  dv_side_t side_i,
  output logic     valid_o,
  output dv_lane_t lane_x_o,
  output dv_lane_t lane_y_o,
  output dv_side_t side_o
);

  logic     valid_q;
  dv_lane_t lane_x_q, lane_y_q, lane_x_d, lane_y_d;
  dv_side_t side_q;

  function automatic dv_lane_t lane_step(dv_lane_t l);
    logic [63:0] r2;
    dv_lane_t    n;
    r2 = {l.r, 1'b0};
    n  = l;
    if (r2 >= {1'b0, l.d}) begin
      r2  = r2 - {1'b0, l.d};
      n.q = {l.q[RatioBits-2:0], 1'b1};
    end else begin
      n.q = {l.q[RatioBits-2:0], 1'b0};
    end
    n.r = r2[62:0];
    return n;
  endfunction

  assign lane_x_d = lane_step(lane_x_i);
  assign lane_y_d = lane_step(lane_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_x_q <= lane_x_d;
      lane_y_q <= lane_y_d;
      side_q   <= side_i;
    end
  end

  assign valid_o  = valid_q;
  assign lane_x_o = lane_x_q;
  assign lane_y_o = lane_y_q;
  assign side_o   = side_q;

endmodule

>>> sv/thumbstick_radial_deadzone.sv
// top level of the thumbstick radial dead zone block
// depends on tsrdz_pkg, tsrdz_sqrt_cell and tsrdz_div_cell
//
// One raw X/Y stick item goes in, one conditioned item comes out. The block
// takes a new item every cycle while not halted: three front stages (abs,
// squares, sum), a row of 32 square root cells (one magnitude bit each),
// three gain stages (subtract, products, clamp choice), a row of 30 divider
// cells (one ratio bit per axis each), a scaling stage and the output
// register. The whole pipe moves as one; it only halts while a result sits
// in the output register and the receiver stalls. The dead zone fraction is
// captured with each item at the input, so writes take effect for the next
// item accepted.
module thumbstick_radial_deadzone
  import tsrdz_pkg::*;
#(
  parameter int unsigned AXIS_FULL_SCALE = AxisFullScaleDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               dead_zone_fraction_we_i,
  input  logic        [16:0] dead_zone_fraction_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] scaled_x_o,
  output logic signed [15:0] scaled_y_o,
  output logic               inside_dead_zone_o
);

  localparam logic [14:0] AfsW   = 15'(AXIS_FULL_SCALE);
  localparam logic [30:0] Full16 = {AfsW, 16'h0000};

  // global pipe enable: hold only when the result waits and is stalled
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // configuration register
  logic [16:0] frac_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= 17'(FracResetVal);
    end else if (dead_zone_fraction_we_i) begin
      frac_q <= dead_zone_fraction_i;
    end
  end

  // stage 0: absolute values and signs, -32768 becomes 32768
  logic        v0_q;
  logic [16:0] ax0_q, ay0_q, f0_q;
  logic        nx0_q, ny0_q;
  logic [16:0] ax0_d, ay0_d;
  assign ax0_d = raw_x_i[15] ? 17'h10000 - {1'b0, raw_x_i} : {1'b0, raw_x_i};
  assign ay0_d = raw_y_i[15] ? 17'h10000 - {1'b0, raw_y_i} : {1'b0, raw_y_i};

  // stage 1: squares and zone radius in Q16
  logic        v1_q;
  logic [31:0] sqx1_q, sqy1_q;
  logic [30:0] dz1_q;
  logic [16:0] ax1_q, ay1_q;
  logic        nx1_q, ny1_q, fzero1_q, fbig1_q;

  // stage 2: squared magnitude, start of the square root row
  logic        v2_q;
  logic [31:0] mag2;
  sq_data_t    sq2_q;
  sq_side_t    sqs2_q;
  assign mag2 = sqx1_q + sqy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax0_q    <= ax0_d;
      ay0_q    <= ay0_d;
      nx0_q    <= raw_x_i[15];
      ny0_q    <= raw_y_i[15];
      f0_q     <= frac_q;
      sqx1_q   <= 32'(ax0_q) * 32'(ax0_q);
      sqy1_q   <= 32'(ay0_q) * 32'(ay0_q);
      dz1_q    <= 31'(f0_q[15:0]) * 31'(AfsW);
      ax1_q    <= ax0_q;
      ay1_q    <= ay0_q;
      nx1_q    <= nx0_q;
      ny1_q    <= ny0_q;
      fzero1_q <= (f0_q == 17'd0);
      fbig1_q  <= f0_q[16];
      sq2_q.rad  <= {mag2, 32'h0};
      sq2_q.rem  <= '0;
      sq2_q.root <= '0;
      sqs2_q.nx       <= nx1_q;
      sqs2_q.ny       <= ny1_q;
      sqs2_q.ax       <= ax1_q;
      sqs2_q.ay       <= ay1_q;
      sqs2_q.dz       <= dz1_q;
      sqs2_q.f_zero   <= fzero1_q;
      sqs2_q.f_big    <= fbig1_q;
      sqs2_q.mag_zero <= (mag2 == 32'd0);
    end
  end

  // square root row: magnitude in Q16
  logic     sqv [0:SqrtCells];
  sq_data_t sqd [0:SqrtCells];
  sq_side_t sqs [0:SqrtCells];
  assign sqv[0] = v2_q;
  assign sqd[0] = sq2_q;
  assign sqs[0] = sqs2_q;

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    tsrdz_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sqv[i]),
      .data_i  (sqd[i]),
      .side_i  (sqs[i]),
      .valid_o (sqv[i+1]),
      .data_o  (sqd[i+1]),
      .side_o  (sqs[i+1])
    );
  end

  // stage 3: zone test and excess over the zone edge
  sq_side_t    st;
  logic [31:0] mag16;
  logic        in_zone3;
  assign st       = sqs[SqrtCells];
  assign mag16    = sqd[SqrtCells].root;
  assign in_zone3 = mag16 < {1'b0, st.dz};

  logic        v3_q;
  logic [31:0] ex3_q, mag3_q;
  logic [30:0] dz3_q;
  logic [16:0] ax3_q, ay3_q, m3_q;
  logic        nx3_q, ny3_q, zero3_q, zone3_q;

  // stage 4: products for the clamp test and the numerators
  logic        v4_q;
  logic [48:0] lhs4_q, nux4_q, nuy4_q;
  logic [62:0] den4_q;
  logic [16:0] ax4_q, ay4_q, m4_q;
  logic        nx4_q, ny4_q, zero4_q, zone4_q;

  // stage 5: pick clamp or gain path, load the divider row
  logic        v5_q;
  dv_lane_t    lx5_q, ly5_q;
  dv_side_t    ds5_q;
  logic        clamp;
  logic [62:0] ax5, ay5, d5;
  assign clamp = {lhs4_q, 16'h0} > {2'b00, den4_q};
  assign ax5   = clamp ? 63'(ax4_q) : {nux4_q[46:0], 16'h0};
  assign ay5   = clamp ? 63'(ay4_q) : {nuy4_q[46:0], 16'h0};
  assign d5    = clamp ? 63'(m4_q) : den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v3_q <= sqv[SqrtCells];
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex3_q   <= mag16 - {1'b0, st.dz};
      mag3_q  <= mag16;
      dz3_q   <= st.dz;
      ax3_q   <= st.ax;
      ay3_q   <= st.ay;
      m3_q    <= (st.ax > st.ay) ? st.ax : st.ay;
      nx3_q   <= st.nx;
      ny3_q   <= st.ny;
      zero3_q <= st.f_big || st.mag_zero || in_zone3;
      // zero vector reports in zone unless the zone has zero radius
      zone3_q <= st.f_big || (st.mag_zero ? !st.f_zero : in_zone3);
      lhs4_q  <= 49'(m3_q) * 49'(ex3_q);
      nux4_q  <= 49'(ax3_q) * 49'(ex3_q);
      nuy4_q  <= 49'(ay3_q) * 49'(ex3_q);
      den4_q  <= 63'(Full16 - dz3_q) * 63'(mag3_q);
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      m4_q    <= m3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      zero4_q <= zero3_q;
      zone4_q <= zone3_q;
      lx5_q.r  <= ax5;
      lx5_q.d  <= d5;
      lx5_q.q  <= '0;
      lx5_q.ge <= ax5 >= d5;
      ly5_q.r  <= ay5;
      ly5_q.d  <= d5;
      ly5_q.q  <= '0;
      ly5_q.ge <= ay5 >= d5;
      ds5_q.nx       <= nx4_q;
      ds5_q.ny       <= ny4_q;
      ds5_q.zero_out <= zero4_q;
      ds5_q.in_zone  <= zone4_q;
    end
  end

  // divider row: 30 fraction bits per axis
  logic     dvv [0:RatioBits];
  dv_lane_t dvx [0:RatioBits];
  dv_lane_t dvy [0:RatioBits];
  dv_side_t dvs [0:RatioBits];
  assign dvv[0] = v5_q;
  assign dvx[0] = lx5_q;
  assign dvy[0] = ly5_q;
  assign dvs[0] = ds5_q;

  for (genvar k = 0; k < RatioBits; k++) begin : g_div
    tsrdz_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (dvv[k]),
      .lane_x_i (dvx[k]),
      .lane_y_i (dvy[k]),
      .side_i   (dvs[k]),
      .valid_o  (dvv[k+1]),
      .lane_x_o (dvx[k+1]),
      .lane_y_o (dvy[k+1]),
      .side_o   (dvs[k+1])
    );
  end

  // stage 6: ratio times 32767, rounded half up
  dv_lane_t    fx, fy;
  dv_side_t    fs;
  logic [30:0] frx, fry;
  logic [45:0] prx, pry;
  assign fx  = dvx[RatioBits];
  assign fy  = dvy[RatioBits];
  assign fs  = dvs[RatioBits];
  assign frx = fx.ge ? 31'(1) << RatioBits : {1'b0, fx.q};
  assign fry = fy.ge ? 31'(1) << RatioBits : {1'b0, fy.q};
  assign prx = 46'(frx) * 46'(OutOne) + (46'(1) << (RatioBits - 1));
  assign pry = 46'(fry) * 46'(OutOne) + (46'(1) << (RatioBits - 1));

  logic        v6_q;
  logic [15:0] mx6_q, my6_q;
  logic        nx6_q, ny6_q, zone6_q;

  // stage 7: output register, sign put back
  logic signed [15:0] sx_q, sy_q;
  logic               zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v6_q        <= dvv[RatioBits];
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx6_q   <= fs.zero_out ? 16'h0 : prx[45:30];
      my6_q   <= fs.zero_out ? 16'h0 : pry[45:30];
      nx6_q   <= fs.nx;
      ny6_q   <= fs.ny;
      zone6_q <= fs.in_zone;
      sx_q    <= nx6_q ? 16'h0 - mx6_q : mx6_q;
      sy_q    <= ny6_q ? 16'h0 - my6_q : my6_q;
      zone_q  <= zone6_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scaled_x_o         = sx_q;
  assign scaled_y_o         = sy_q;
  assign inside_dead_zone_o = zone_q;

endmodule

>>> sv/tsrdz_checker.sv
// port-level checks for the thumbstick radial dead zone block
// bound to thumbstick_radial_deadzone; no package needed
module tsrdz_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] scaled_x_o,
  input logic signed [15:0] scaled_y_o,
  input logic               inside_dead_zone_o
);

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // in-zone items come out as zero
  a_zone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_dead_zone_o |-> scaled_x_o == 16'sd0 && scaled_y_o == 16'sd0)
    else $error("nonzero output inside dead zone");

  // outputs stay symmetric, never the most negative code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scaled_x_o != 16'sh8000 && scaled_y_o != 16'sh8000)
    else $error("output out of range");

endmodule

bind thumbstick_radial_deadzone tsrdz_checker u_tsrdz_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .scaled_x_o         (scaled_x_o),
  .scaled_y_o         (scaled_y_o),
  .inside_dead_zone_o (inside_dead_zone_o)
);

>>> tb/tb_thumbstick_radial_deadzone.sv
// testbench for thumbstick_radial_deadzone: random and directed stick items
// against a bit-accurate predictor of the radial dead zone; needs tsrdz_pkg
// and the block's rtl only
module tb_thumbstick_radial_deadzone;
  import tsrdz_pkg::*;

  localparam int unsigned FULL_SCALE = AxisFullScaleDef;
  localparam int unsigned FRAC_ONE   = 65536;
  localparam int unsigned PIPE_DEPTH = 70;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               in_zone;
  } stick_out_t;

  // integer square root of a 64-bit value
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // ratio a/d cut to 30 fraction bits, times 32767, rounded half up
  function automatic logic [63:0] ratio_to_q15(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = a;
    if (a >= d) begin
      q = 64'd1 << RatioBits;
    end else begin
      for (int i = 0; i < RatioBits; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
    end
    return (q * OutOne + (64'd1 << (RatioBits - 1))) >> RatioBits;
  endfunction

  function automatic logic [15:0] signed_out(input logic [63:0] mag, input logic neg);
    return neg ? 16'(17'h10000 - mag[16:0]) : mag[15:0];
  endfunction

  function automatic stick_out_t deadzone_predict(input logic [16:0] frac,
                                                  input logic [15:0] rx,
                                                  input logic [15:0] ry);
    stick_out_t o;
    logic nx, ny;
    logic [63:0] ax, ay, mag2, mag16, dz, m, excess, lhs, den, ox, oy;
    nx = rx[15];
    ny = ry[15];
    ax = nx ? 64'h10000 - rx : 64'(rx);
    ay = ny ? 64'h10000 - ry : 64'(ry);
    o = '{sx: 16'sd0, sy: 16'sd0, in_zone: 1'b1};
    if (frac >= FRAC_ONE) return o;
    mag2 = ax * ax + ay * ay;
    if (mag2 == 0) begin
      o.in_zone = (frac != 0);
      return o;
    end
    mag16 = root64(mag2 << 32);
    dz = 64'(frac) * FULL_SCALE;
    if (mag16 < dz) return o;
    m = (ax > ay) ? ax : ay;
    excess = mag16 - dz;
    lhs = (m * excess) << 16;
    den = ((64'(FULL_SCALE) << 16) - dz) * mag16;
    if (lhs > den) begin
      // overshoot: clamp by the larger axis
      ox = ratio_to_q15(ax, m);
      oy = ratio_to_q15(ay, m);
    end else begin
      ox = ratio_to_q15((ax * excess) << 16, den);
      oy = ratio_to_q15((ay * excess) << 16, den);
    end
    o.sx = signed_out(ox, nx);
    o.sy = signed_out(oy, ny);
    o.in_zone = 1'b0;
    return o;
  endfunction

  // holds the expected conditioned items in order, in a ring
  class stick_scoreboard;
    stick_out_t  pending[128];
    logic [6:0]  wr_ptr = '0;
    logic [6:0]  rd_ptr = '0;
    int unsigned count;
    int unsigned errors;
    int unsigned checked;
    int unsigned zone_hits;

    function int unsigned outstanding();
      return count;
    endfunction

    function void note_item(input logic [16:0] frac, input logic [15:0] rx,
                            input logic [15:0] ry);
      pending[wr_ptr] = deadzone_predict(frac, rx, ry);
      wr_ptr = wr_ptr + 7'd1;
      count++;
    endfunction

    function void check_result(input stick_out_t got);
      stick_out_t exp;
      if (count == 0) begin
        $error("unexpected result item x=%0d y=%0d", got.sx, got.sy);
        errors++;
        return;
      end
      exp = pending[rd_ptr];
      rd_ptr = rd_ptr + 7'd1;
      count--;
      checked++;
      if (got.in_zone) zone_hits++;
      if (got.sx !== exp.sx) begin
        $error("scaled_x: expected %0d, actual %0d", exp.sx, got.sx);
        errors++;
      end
      if (got.sy !== exp.sy) begin
        $error("scaled_y: expected %0d, actual %0d", exp.sy, got.sy);
        errors++;
      end
      if (got.in_zone !== exp.in_zone) begin
        $error("inside_dead_zone: expected %0d, actual %0d", exp.in_zone, got.in_zone);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic        [16:0] cfg_frac = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] raw_x = '0;
  logic signed [15:0] raw_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] scaled_x;
  logic signed [15:0] scaled_y;
  logic               in_zone;

  logic [16:0] frac_now = 17'(FracResetVal);  // predictor's copy of the register
  logic        calm = 1'b0;                   // no idling on either side while set
  int unsigned sent = 0;
  stick_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  thumbstick_radial_deadzone DUT (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .dead_zone_fraction_we_i (cfg_we),
    .dead_zone_fraction_i    (cfg_frac),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .raw_x_i                 (raw_x),
    .raw_y_i                 (raw_y),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .scaled_x_o              (scaled_x),
    .scaled_y_o              (scaled_y),
    .inside_dead_zone_o      (in_zone)
  );

  // receiver: check on accept, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_result('{scaled_x, scaled_y, in_zone});
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
    end
  end

  // one item, with a random gap first; note it when accepted
  task automatic send_item(input logic [15:0] x, input logic [15:0] y);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    raw_x <= x;
    raw_y <= y;
    do @(posedge clk_i); while (in_stall);
    sb.note_item(frac_now, x, y);
    sent++;
  endtask

  // drain, let the pipe empty, then write the register
  task automatic set_fraction(input logic [16:0] f);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_frac <= f;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    frac_now = f;
  endtask

  // random item mix: full range, near the zone edge, near the X axis, and extremes
  task automatic random_item();
    int unsigned kind;
    logic [15:0] x, y;
    kind = $urandom_range(9);
    x = 16'($urandom());
    y = 16'($urandom());
    if (kind < 2) begin
      x = 16'($urandom_range(8000) - 4000);
      y = 16'($urandom_range(8000) - 4000);
    end else if (kind == 2) begin
      y = 16'($urandom_range(6) - 3);
    end else if (kind == 3) begin
      x = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    end
    send_item(x, y);
  endtask

  initial begin
    logic [16:0] fracs[7];
    fracs = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd131071, 17'd32768, 17'd20000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset fraction: zero vector, extremes, edge cases
    send_item(16'sd0, 16'sd0);
    send_item(16'sh7fff, 16'sd0);
    send_item(16'sh8000, 16'sd0);
    send_item(16'sd0, 16'sh8000);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh7fff, 16'sh7fff);
    send_item(16'sh7fff, 16'sh8000);
    send_item(16'sd2293, 16'sd0);
    send_item(16'sd2294, 16'sd0);
    send_item(16'sd1621, -16'sd1622);
    send_item(16'sd23170, 16'sd23170);
    send_item(-16'sd1, 16'sd1);
    send_item(16'sh5555, 16'shaaaa);
    // fraction zero passes through, at or above one forces zeros
    set_fraction(17'd0);
    send_item(16'sd0, 16'sd0);
    send_item(16'sd1, -16'sd1);
    send_item(16'sh8000, 16'sh7fff);
    set_fraction(17'd65536);
    send_item(16'sh7fff, 16'sh7fff);
    set_fraction(17'd131071);
    send_item(16'sh8000, 16'sd0);

    // random phases over several fractions, one calm stretch in the middle
    for (int p = 0; p < 8; p++) begin
      set_fraction(p < 7 ? fracs[p] : 17'($urandom_range(65535)));
      calm = (p == 4);
      for (int i = 0; i < 215; i++) random_item();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    $display("%0d items sent, %0d results checked, %0d inside the zone, 11 fraction settings",
             sent, sb.checked, sb.zone_hits);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
